// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the character-LCD sequencer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hdl/clws_pkg.sv =====
// Types, constants and helpers for the character-LCD write sequencer
package clws_pkg;

	// Decimal printing
	localparam int MAX_DIGITS = 7;
	localparam int NUM_W = 24;
	localparam int BCD_W = 4 * MAX_DIGITS;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	// Byte building
	localparam logic [7:0] CURSOR_BASE = 8'h80;
	localparam logic [7:0] ROW_OFFSET = 8'h40;
	localparam logic [7:0] ASCII_ZERO = 8'd48;

	// Configuration port
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	// Reset values of the timing registers
	localparam logic [15:0] RST_PULSE_HIGH_EIGHT = 16'd2000;
	localparam logic [15:0] RST_PULSE_HIGH_FOUR = 16'd30000;
	localparam logic [15:0] RST_PULSE_LOW_FOUR = 16'd2000;

	// Power of ten, worked out at elaboration
	function automatic longint unsigned pow10(input int n);
		longint unsigned p;
		p = 1;
		for (int i = 0; i < n; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

	localparam longint unsigned MAX_VAL = pow10(MAX_DIGITS) - 1;

	typedef enum logic [1:0] {
		CMD_INSTR  = 2'd0,
		CMD_DATA   = 2'd1,
		CMD_CURSOR = 2'd2,
		CMD_NUMBER = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BUS_MODE        = 2'd0,
		CFG_PULSE_HIGH_EIGHT = 2'd1,
		CFG_PULSE_HIGH_FOUR = 2'd2,
		CFG_PULSE_LOW_FOUR  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [7:0]       byte_value;
		logic             row;
		logic [5:0]       column;
		logic [NUM_W-1:0] number;
	} req_t;

	typedef struct packed {
		logic        reg_select;
		logic        read_write;
		logic        enable;
		logic [7:0]  bus;
		logic [15:0] hold_us;
		logic        last;
	} phase_t;

	// Controller to datapath
	typedef struct packed {
		logic load_req;
		logic conv_step;
		logic skip;
		logic load_digit;
		logic emit;
		logic adv_digit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_number;
		logic conv_done;
		logic digit_zero;
		logic idx_zero;
		logic byte_last;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hdl/char_lcd_write_sequencer.sv =====
// Character-LCD write sequencer: request in, timed pin phases out, one beat per phase.
// A request is taken only while the block is idle. An instruction, data or cursor request
// is loaded and then sent at one phase per cycle while the output is free: two phases in eight-bit mode, four in
// four-bit mode. A number request is loaded, passes bit by bit through the 24-bit shift-and-add-three
// binary to decimal converter, suppresses leading zeros at one per cycle (up to six), then for each
// printed digit takes a load step and sends its two or four phases.
// Phases leave through a single output register at one per cycle while the sink takes them.
// Configuration writes apply at once and should be made only while the block is idle.
module char_lcd_write_sequencer import clws_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  req_t                 in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output phase_t               out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_st;

	// Sequencing control
	clws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_number (in_data.cmd == CMD_NUMBER),
		.in_ready  (in_ready),
		.st        (dp_st),
		.cmd       (dp_cmd)
	);

	// Byte building, conversion and phase output
	clws_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (dp_cmd),
		.st        (dp_st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== hdl/clws_ctrl.sv =====
// Sequencing state machine for the character-LCD write sequencer
`include "assert_macros.svh"
module clws_ctrl import clws_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_number,
	output logic       in_ready,
	input  dp_status_t st,
	output dp_cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_LOAD = 5'b01000,
		ST_SEND = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// Decide next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d = in_number ? ST_CONV : ST_SEND;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (st.conv_done) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (st.digit_zero && !st.idx_zero) begin
					cmd.skip = 1'b1;
				end else begin
					cmd.load_digit = 1'b1;
					state_d = ST_SEND;
				end
			end
			ST_LOAD: begin
				cmd.load_digit = 1'b1;
				state_d = ST_SEND;
			end
			ST_SEND: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.byte_last) begin
						if (st.is_number && !st.idx_zero) begin
							cmd.adv_digit = 1'b1;
							state_d = ST_LOAD;
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_AT(a_accept_leaves_idle, clk, arst_n, (in_valid && in_ready) |=> (state_q != ST_IDLE))
	`ASSERT_NEVER(a_skip_and_load, clk, arst_n, cmd.skip && cmd.load_digit)
	`ASSERT_AT(a_adv_on_byte_end, clk, arst_n, cmd.adv_digit |-> (cmd.emit && st.byte_last))

endmodule

// ===== hdl/clws_datapath.sv =====
// Byte, digit conversion, phase and output registers of the LCD sequencer
`include "assert_macros.svh"
module clws_datapath import clws_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  req_t                 req,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  dp_cmd_t              cmd,
	output dp_status_t           st,
	output logic                 out_valid,
	input  logic                 out_ready,
	output phase_t               out_data
);

	logic             bus_mode_q;
	logic [15:0]      phe8_q, phh4_q, phl4_q;
	logic             rs_q, is_num_q;
	logic [7:0]       byte_q;
	logic [NUM_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [1:0]       ph_q;
	logic             out_valid_q;
	phase_t           out_q;

	logic [BCD_W-1:0] bcd_adj;
	logic [3:0]       digit;
	logic [7:0]       req_byte;
	logic             req_rs;
	logic [NUM_W-1:0] num_sat;
	logic [3:0]       nib;
	logic             byte_last;
	phase_t           phase;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_mode_q <= 1'b1;
			phe8_q <= RST_PULSE_HIGH_EIGHT;
			phh4_q <= RST_PULSE_HIGH_FOUR;
			phl4_q <= RST_PULSE_LOW_FOUR;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BUS_MODE:         bus_mode_q <= cfg_data[0];
				CFG_PULSE_HIGH_EIGHT: phe8_q <= cfg_data;
				CFG_PULSE_HIGH_FOUR:  phh4_q <= cfg_data;
				CFG_PULSE_LOW_FOUR:   phl4_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Build the byte for a plain request
	always_comb begin
		req_rs = 1'b0;
		req_byte = req.byte_value;
		case (req.cmd)
			CMD_INSTR: begin
				req_rs = 1'b0;
				req_byte = req.byte_value;
			end
			CMD_DATA: begin
				req_rs = 1'b1;
				req_byte = req.byte_value;
			end
			CMD_CURSOR: begin
				req_rs = 1'b0;
				req_byte = CURSOR_BASE + {2'b00, req.column} + (req.row ? ROW_OFFSET : 8'd0);
			end
			CMD_NUMBER: begin
				req_rs = 1'b1;
				req_byte = ASCII_ZERO;
			end
			default: begin
			end
		endcase
	end

	// Clamp the number to the largest printable value
	assign num_sat = (64'(req.number) > MAX_VAL) ? NUM_W'(MAX_VAL) : req.number;

	// Add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	assign digit = bcd_q[idx_q*4 +: 4];

	// Request, conversion and digit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			ph_q <= '0;
			is_num_q <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				is_num_q <= (req.cmd == CMD_NUMBER);
				cnt_q <= CNT_W'(NUM_W);
				idx_q <= IDX_W'(MAX_DIGITS - 1);
				ph_q <= '0;
			end
			if (cmd.conv_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.skip || cmd.adv_digit) begin
				idx_q <= idx_q - 1'b1;
			end
			if (cmd.load_digit) begin
				ph_q <= '0;
			end else if (cmd.emit) begin
				ph_q <= ph_q + 1'b1;
			end
		end
	end

	// Payload of the request and the conversion
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			rs_q <= req_rs;
			byte_q <= req_byte;
			bin_q <= num_sat;
			bcd_q <= '0;
		end
		if (cmd.conv_step) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[NUM_W-1]};
			bin_q <= {bin_q[NUM_W-2:0], 1'b0};
		end
		if (cmd.load_digit) begin
			rs_q <= 1'b1;
			byte_q <= ASCII_ZERO + {4'b0000, digit};
		end
	end

	// Pin state of the current phase
	assign byte_last = bus_mode_q ? (ph_q == 2'd3) : (ph_q == 2'd1);
	assign nib = ph_q[1] ? byte_q[3:0] : byte_q[7:4];

	always_comb begin
		phase.reg_select = rs_q;
		phase.read_write = 1'b0;
		phase.enable = ~ph_q[0];
		phase.bus = bus_mode_q ? {nib, 4'b0000} : byte_q;
		if (bus_mode_q) begin
			phase.hold_us = ph_q[0] ? phl4_q : phh4_q;
		end else begin
			phase.hold_us = ph_q[0] ? 16'd0 : phe8_q;
		end
		phase.last = byte_last && (!is_num_q || (idx_q == '0));
	end

	// Output register: load a phase beat or drop the taken one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= phase;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign st.is_number = is_num_q;
	assign st.conv_done = (cnt_q == CNT_W'(1));
	assign st.digit_zero = (digit == 4'd0);
	assign st.idx_zero = (idx_q == '0);
	assign st.byte_last = byte_last;
	assign st.out_free = !out_valid_q || out_ready;

	`ASSERT_AT(a_emit_into_free_slot, clk, arst_n, cmd.emit |-> (!out_valid_q || out_ready))
	`ASSERT_NEVER(a_conv_past_end, clk, arst_n, cmd.conv_step && (cnt_q == '0))

endmodule
